// ===== sv/ptst_pkg.sv =====
// Package for the pan and tilt step tracker: register indexes, step rules and the axis step function.
package ptst_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		REG_TILT_LOWER  = 3'd0,
		REG_TILT_UPPER  = 3'd1,
		REG_PAN_LOWER   = 3'd2,
		REG_PAN_UPPER   = 3'd3,
		REG_CENTER_REF  = 3'd4
	} cfg_index_t;

	// Three rules per axis, element 0 is applied first.
	typedef logic [2:0][6:0] rule_vec_t;

	localparam rule_vec_t TILT_TH = {7'd16, 7'd32, 7'd64};
	localparam rule_vec_t TILT_ST = {7'd1, 7'd1, 7'd2};
	localparam rule_vec_t PAN_TH  = {7'd64, 7'd48, 7'd16};
	localparam rule_vec_t PAN_ST  = {7'd5, 7'd3, 7'd1};

	localparam byte_t FRAME_END    = 8'd255;
	localparam byte_t RST_TILT_LO  = 8'd80;
	localparam byte_t RST_TILT_HI  = 8'd110;
	localparam byte_t RST_PAN_LO   = 8'd10;
	localparam byte_t RST_PAN_HI   = 8'd170;
	localparam byte_t RST_CENTER   = 8'd128;
	localparam byte_t RST_PAN_POS  = 8'd90;
	localparam byte_t RST_TILT_POS = 8'd91;
	localparam logic signed [9:0] DEAD_BAND = 10'sd16;

	// Error of one byte against the reference, wrapped to eight bits and sign-extended.
	function automatic logic signed [9:0] wrap_err(input byte_t ref_v, input byte_t b);
		logic [7:0] d;
		d = ref_v - b;
		return $signed({{2{d[7]}}, d});
	endfunction

	// Sequential step rules; each rule rechecks the limit and saturates to 0..255.
	function automatic byte_t step_axis(input byte_t ang, input logic signed [9:0] err,
			input byte_t lo, input byte_t hi, input rule_vec_t th, input rule_vec_t st);
		logic signed [9:0] a;
		logic signed [9:0] t;
		a = $signed({2'b00, ang});
		if (err < -DEAD_BAND) begin
			for (int i = 0; i < 3; i++) begin
				t = $signed({3'b000, th[i]});
				if (a > $signed({2'b00, lo}) && err < -t) begin
					a = a - $signed({3'b000, st[i]});
					if (a < 10'sd0)
						a = 10'sd0;
				end
			end
		end
		if (err > DEAD_BAND) begin
			for (int i = 0; i < 3; i++) begin
				t = $signed({3'b000, th[i]});
				if (a < $signed({2'b00, hi}) && err > t) begin
					a = a + $signed({3'b000, st[i]});
					if (a > 10'sd255)
						a = 10'sd255;
				end
			end
		end
		return a[7:0];
	endfunction

endpackage

// ===== sv/pan_tilt_step_tracker_top.sv =====
// Top level of the pan and tilt step tracker: input register, step logic and result register.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------------------------
//  s_*     | in        | s_tvalid / s_tready    | s_tdata[7:0] = rx_byte
//  m_*     | out       | m_tvalid / m_tready    | m_tdata[7:0] = pan_position,
//          |           |                        | m_tdata[15:8] = tilt_position
//  cfg_*   | in        | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[7:0]
//
// Each item is held in the input register and stepped from there; the result of a frame end
// is written into the result register and appears on m_tdata, and one item can be taken every
// cycle unless a frame end is waiting in the input register behind a held result.
// Reset clears both valid flags and loads the register and angle reset values.
// A frame-end item waits in the input register only while a result is held back by m_tready;
// other items never wait. Configuration writes are taken in every cycle.
module pan_tilt_step_tracker_top
	import ptst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] pan_position, [15:8] tilt_position
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// Configuration registers.
	byte_t tilt_lo_q, tilt_hi_q, pan_lo_q, pan_hi_q, center_q;

	// Tracker state: the two bytes before the current one and the present angles.
	byte_t older_q, newer_q, pan_q, tilt_q;

	// Input register.
	logic  valid_s1;
	byte_t byte_s1;

	// Result register.
	logic  out_valid_q;
	byte_t out_pan_q, out_tilt_q;

	logic  out_free;
	logic  advance;
	logic  is_end;
	byte_t pan_next, tilt_next;

	assign cfg_ready = 1'b1;

	// The result slot is free when empty or being emptied in this cycle.
	assign out_free = !out_valid_q || m_tready;
	assign is_end   = (byte_s1 == FRAME_END);
	// Ordinary bytes only shift the history; a frame end also needs the result slot.
	assign advance  = valid_s1 && (!is_end || out_free);
	assign s_tready = !valid_s1 || advance;

	// Pan follows the byte just before the frame end, tilt the one before that.
	always_comb begin
		pan_next  = step_axis(pan_q, wrap_err(center_q, newer_q), pan_lo_q, pan_hi_q,
			PAN_TH, PAN_ST);
		tilt_next = step_axis(tilt_q, wrap_err(center_q, older_q), tilt_lo_q, tilt_hi_q,
			TILT_TH, TILT_ST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_lo_q <= RST_TILT_LO;
			tilt_hi_q <= RST_TILT_HI;
			pan_lo_q  <= RST_PAN_LO;
			pan_hi_q  <= RST_PAN_HI;
			center_q  <= RST_CENTER;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TILT_LOWER: tilt_lo_q <= cfg_data;
				REG_TILT_UPPER: tilt_hi_q <= cfg_data;
				REG_PAN_LOWER:  pan_lo_q  <= cfg_data;
				REG_PAN_UPPER:  pan_hi_q  <= cfg_data;
				REG_CENTER_REF: center_q  <= cfg_data;
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
			pan_q   <= RST_PAN_POS;
			tilt_q  <= RST_TILT_POS;
		end else if (advance) begin
			older_q <= newer_q;
			newer_q <= byte_s1;
			if (is_end) begin
				pan_q  <= pan_next;
				tilt_q <= tilt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && is_end;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			out_pan_q  <= pan_next;
			out_tilt_q <= tilt_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_tilt_q, out_pan_q};

endmodule

// ===== sv/ptst_checker.sv =====
// Port checker for the pan and tilt step tracker, bound to the top level.
module ptst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A held result keeps its value until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The input side stalls only behind a pending result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// A draining output always leaves room for a new item.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// After a stall the waiting frame end produces a result once the output frees.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready ##1 m_tready |=> m_tvalid)
		else $error("stalled frame end gave no result");

endmodule

bind pan_tilt_step_tracker_top ptst_checker u_ptst_checker (.*);

// ===== tb/pan_tilt_step_checker.sv =====
// Checker for the pan and tilt step tracker: predicts servo angles and compares every result.
module pan_tilt_step_checker
	import ptst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] pan_position, [15:8] tilt_position
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          pending_results,
	output int          result_count,
	output int          mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		byte_t tilt;
		byte_t pan;
	} angles_t;

	angles_t expected_angles[$];

	byte_t tilt_lo, tilt_hi, pan_lo, pan_hi, center_ref;
	byte_t older_byte, newer_byte, pan_pred, tilt_pred;
	int    errors;
	int    results_seen;

	// Signed distance of a byte from the centre, wrapped to eight bits.
	function automatic int axis_error(input byte_t b);
		logic signed [7:0] d;
		d = center_ref - b;
		return d;
	endfunction

	// Three rules in order; each one rechecks the limit and clamps to 0..255.
	function automatic byte_t step_angle(input byte_t angle, input int err, input byte_t lo,
			input byte_t hi, input int th0, input int th1, input int th2,
			input int st0, input int st1, input int st2);
		int a;
		int th[3];
		int st[3];
		a = angle;
		th = '{th0, th1, th2};
		st = '{st0, st1, st2};
		if (err < -16) begin
			for (int i = 0; i < 3; i++) begin
				if (a > int'(lo) && err < -th[i])
					a = (a - st[i] < 0) ? 0 : a - st[i];
			end
		end
		if (err > 16) begin
			for (int i = 0; i < 3; i++) begin
				if (a < int'(hi) && err > th[i])
					a = (a + st[i] > 255) ? 255 : a + st[i];
			end
		end
		return byte_t'(a);
	endfunction

	task automatic take_byte(input byte_t b);
		angles_t next;
		if (b == FRAME_END) begin
			pan_pred = step_angle(pan_pred, axis_error(newer_byte), pan_lo, pan_hi,
				16, 48, 64, 1, 3, 5);
			tilt_pred = step_angle(tilt_pred, axis_error(older_byte), tilt_lo, tilt_hi,
				64, 32, 16, 2, 1, 1);
			next.pan = pan_pred;
			next.tilt = tilt_pred;
			expected_angles.push_back(next);
		end
		older_byte = newer_byte;
		newer_byte = b;
	endtask

	task automatic check_result(input logic [15:0] d);
		angles_t want;
		results_seen++;
		if (expected_angles.size() == 0) begin
			if (errors < 10)
				$display("%0t: result pan %0d tilt %0d arrived with nothing expected",
					$time, d[7:0], d[15:8]);
			errors++;
		end else begin
			want = expected_angles.pop_front();
			if (d[7:0] !== want.pan || d[15:8] !== want.tilt) begin
				if (errors < 10)
					$display("%0t: result %0d: pan expected %0d got %0d, tilt expected %0d got %0d",
						$time, results_seen, want.pan, d[7:0], want.tilt, d[15:8]);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_lo = RST_TILT_LO;
			tilt_hi = RST_TILT_HI;
			pan_lo = RST_PAN_LO;
			pan_hi = RST_PAN_HI;
			center_ref = RST_CENTER;
			older_byte = '0;
			newer_byte = '0;
			pan_pred = RST_PAN_POS;
			tilt_pred = RST_TILT_POS;
			errors = 0;
			results_seen = 0;
			expected_angles.delete();
			pending_results <= 0;
			result_count <= 0;
			mismatch_count <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TILT_LOWER: tilt_lo = cfg_data;
					REG_TILT_UPPER: tilt_hi = cfg_data;
					REG_PAN_LOWER:  pan_lo = cfg_data;
					REG_PAN_UPPER:  pan_hi = cfg_data;
					REG_CENTER_REF: center_ref = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
			pending_results <= expected_angles.size();
			result_count <= results_seen;
			mismatch_count <= errors;
		end
	end

endmodule

// ===== tb/tb_pan_tilt_step_tracker_top.sv =====
// Testbench top for the pan and tilt step tracker: clock, reset, stimulus and verdict.
module tb_pan_tilt_step_tracker_top
	import ptst_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// The run is cut off here; a correct run needs a small fraction of this.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles to let pass once nothing is expected, covering the two-stage pipeline.
	localparam int SETTLE_CYCLES = 4;
	// Length of the long receiver hold-off that fills the block up.
	localparam int HOLD_OFF_CYCLES = 64;
	// An index past the last register; writes to it must leave every register alone.
	localparam logic [2:0] REG_STRAY = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [7:0] pan_position, [15:8] tilt_position
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	int pending_results;
	int result_count;
	int mismatch_count;

	// Idling percentages for the sender and the receiver, changed from phase to phase.
	int idle_pct = 0;
	int stall_pct = 0;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit hold_req = 1'b0;

	// The stimulus keeps its own copy of the centre so it can aim bytes at either side.
	byte_t center_now = RST_CENTER;
	int    bytes_sent = 0;
	int    cfg_writes = 0;
	int    cycle_count = 0;

	pan_tilt_step_tracker_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pan_tilt_step_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.result_count    (result_count),
		.mismatch_count  (mismatch_count)
	);

	// 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: if the run has not finished by the limit, something has hung.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Receiver. It stalls at random at the current rate, and on request holds m_tready low
	// for a long stretch so that results back up and the block has to refuse new items.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++)
					@(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offers one item, first idling for a random number of cycles at the current rate.
	// tvalid is left high on return so that back-to-back items keep it high throughout.
	task automatic send_byte(input byte_t b);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
	endtask

	// A well-formed frame: tilt byte, pan byte, then the frame end marker.
	task automatic send_frame(input byte_t tilt_b, input byte_t pan_b);
		send_byte(tilt_b);
		send_byte(pan_b);
		send_byte(FRAME_END);
	endtask

	// Stops offering items and waits until every expected result has come out, then lets
	// the pipeline run empty, since bytes that produce no result may still be in flight.
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; cfg_valid stays high so that a run of writes is back to back.
	task automatic write_reg(input logic [2:0] idx, input byte_t v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_writes++;
	endtask

	// Writes all five registers in one burst; only ever called with the block idle.
	task automatic apply_settings(input byte_t tl, input byte_t tu, input byte_t pl,
			input byte_t pu, input byte_t centre);
		write_reg(REG_TILT_LOWER, tl);
		write_reg(REG_TILT_UPPER, tu);
		write_reg(REG_PAN_LOWER, pl);
		write_reg(REG_PAN_UPPER, pu);
		write_reg(REG_CENTER_REF, centre);
		cfg_valid <= 1'b0;
		center_now = centre;
	endtask

	// A byte for one axis. Half the time, when a drift is asked for, the byte is placed so
	// that the error lies outside the dead band on the chosen side, which walks the angle
	// into its limits and into saturation over a phase.
	function automatic byte_t axis_byte(input int drift);
		if (drift == 0 || $urandom_range(1) == 0)
			return byte_t'($urandom_range(255));
		if (drift > 0)
			return center_now - byte_t'($urandom_range(127, 17));
		return center_now + byte_t'($urandom_range(128, 17));
	endfunction

	// A random phase: mostly well-formed frames, with some broken frames (frame end after
	// only one byte) and loose noise bytes. A third of the way in the receiver is asked
	// for its long hold-off while items keep coming; two thirds in, the sender pauses
	// until every result is out.
	task automatic run_phase(input int n_items, input int drift);
		int  sent;
		int  roll;
		bit  held;
		bit  paused;
		sent = 0;
		held = 1'b0;
		paused = 1'b0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll < 80) begin
				send_frame(axis_byte(drift), axis_byte(drift));
				sent += 3;
			end else if (roll < 90) begin
				send_byte(axis_byte(drift));
				send_byte(FRAME_END);
				sent += 2;
			end else begin
				send_byte(byte_t'($urandom_range(255)));
				sent += 1;
			end
			if (!held && sent >= n_items / 3) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && sent >= 2 * n_items / 3) begin
				paused = 1'b1;
				drain();
			end
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset register values. The very first item is a frame
		// end, so both axes are stepped from the cleared byte history, whose error wraps
		// to the most negative value.
		send_byte(FRAME_END);
		send_frame(8'd0, 8'd0);       // largest downward error on both axes
		send_frame(8'd1, 8'd1);       // largest upward error
		send_frame(8'd128, 8'd128);   // no error at all
		send_frame(8'd112, 8'd144);   // exactly on the dead band edges, no movement
		send_frame(8'd111, 8'd145);   // just outside the dead band
		send_frame(8'd63, 8'd64);     // tilt just past its largest threshold, pan on it
		send_byte(FRAME_END);         // frame ends back to back: the newer history byte is 255
		drain();

		// A write to an index past the register file must change nothing.
		write_reg(REG_STRAY, 8'd0);
		cfg_valid <= 1'b0;
		send_frame(8'd200, 8'd40);
		drain();

		// Limits above the nominal range and a centre of zero: tilt may only rise, and
		// bytes just past the midpoint wrap to opposite error signs.
		apply_settings(8'd200, 8'd250, 8'd0, 8'd255, 8'd0);
		send_frame(8'd127, 8'd129);
		send_frame(8'd129, 8'd127);
		drain();

		// Random phases, each with its own register setting and idling pattern.
		idle_pct = 0;
		stall_pct = 0;
		apply_settings(RST_TILT_LO, RST_TILT_HI, RST_PAN_LO, RST_PAN_HI, RST_CENTER);
		run_phase(330, 0);

		// Widest limits, driven upwards so both angles saturate at the top.
		idle_pct = 58;
		stall_pct = 0;
		apply_settings(8'd0, 8'd255, 8'd0, 8'd255, RST_CENTER);
		run_phase(330, 1);

		// Crossed limits at the top of the nominal range; most steps are blocked.
		idle_pct = 0;
		stall_pct = 58;
		apply_settings(8'd180, 8'd0, 8'd180, 8'd0, 8'd255);
		run_phase(330, 0);

		// Widest limits again, driven downwards into saturation at zero.
		idle_pct = 31;
		stall_pct = 31;
		apply_settings(8'd0, 8'd255, 8'd0, 8'd255, 8'd60);
		run_phase(330, -1);

		idle_pct = 0;
		stall_pct = 0;
		apply_settings(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
			byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
			byte_t'($urandom_range(255)));
		run_phase(330, 1);

		idle_pct = 31;
		stall_pct = 31;
		apply_settings(byte_t'($urandom_range(180)), byte_t'($urandom_range(180)),
			byte_t'($urandom_range(180)), byte_t'($urandom_range(180)),
			byte_t'($urandom_range(255)));
		run_phase(330, -1);

		$display("Run sent %0d bytes and checked %0d angle results over %0d register writes,",
			bytes_sent, result_count, cfg_writes);
		$display("with idle and stall mixes, long receiver hold-offs and drift to both limits.");
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
